@@ rtl/elliptical_skin_tone_score_core_macros.svh @@
// ----------------------------------------------------------------------------
// Elliptical skin tone score: assertion macros
// Concurrent checks on clk_i with reset rst_ni; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ELLIPTICAL_SKIN_TONE_SCORE_CORE_MACROS_SVH
`define ELLIPTICAL_SKIN_TONE_SCORE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define EST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define EST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EST_ASSERT(lbl, prop, msg)
`define EST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/est_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// est_pkg
// Types and constants shared by the elliptical skin tone score core.
// ----------------------------------------------------------------------------
package est_pkg;

  typedef enum logic [1:0] {
    SEG_MID,
    SEG_LOW,
    SEG_HIGH
  } seg_e;

  typedef enum logic [2:0] {
    REG_LUMA_KNEES     = 3'd0,
    REG_LUMA_LIMITS    = 3'd1,
    REG_EDGE_WIDTHS    = 3'd2,
    REG_CENTER_WIDTHS  = 3'd3,
    REG_CLUSTER_CENTER = 3'd4,
    REG_ELLIPSE_OFFSET = 3'd5,
    REG_ROTATION       = 3'd6,
    REG_INV_AXES       = 3'd7
  } reg_idx_e;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_red;
    logic [7:0] chroma_blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] skin_score;
  } score_t;

  typedef struct packed {
    logic [15:0] luma_knees;
    logic [15:0] luma_limits;
    logic [31:0] edge_widths;
    logic [31:0] center_widths;
    logic [31:0] cluster_center;
    logic [31:0] ellipse_offset;
    logic [31:0] rotation;
    logic [47:0] inv_axes;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    luma_knees:     16'd48253,
    luma_limits:    16'd60176,
    edge_widths:    32'd236390932,
    center_widths:  32'd788014787,
    cluster_center: 32'd2550492513,
    ellipse_offset: 32'd40436122,
    rotation:       32'd617270177,
    inv_axes:       48'd1429972477354
  };

  // Classified pixel handed from the front end to the back end
  typedef struct packed {
    seg_e       seg;
    logic       ramp;
    logic [7:0] step;
    logic [8:0] lin;
    logic [7:0] span_d;
    logic [7:0] cr;
    logic [7:0] cb;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  // Chroma cluster means at the high knee and their luma ramps
  localparam logic [7:0] BASE_CR       = 8'd154;
  localparam logic [7:0] BASE_CB       = 8'd108;
  localparam logic [4:0] SPAN_CR_LO    = 5'd10;
  localparam logic [4:0] SPAN_CR_HI    = 5'd22;
  localparam logic [4:0] SPAN_CB_LO    = 5'd10;
  localparam logic [4:0] SPAN_CB_HI    = 5'd10;

  localparam int DIV_Q_W     = 24;
  localparam int DIV1_NUM_W  = 24;
  localparam int DIV1_DEN_W  = 8;
  localparam int DIV2_NUM_W  = 37;
  localparam int DIV2_DEN_W  = 25;

  localparam logic [63:0] HALF_Q40 = 64'h0000_0080_0000_0000;

endpackage

@@ rtl/est_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// est_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface est_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/est_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// est_front
// Accepts pixels and classifies luma against the knees and limits.
// ----------------------------------------------------------------------------
module est_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  est_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  input  est_pkg::pixel_t  in_data_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output est_pkg::item_t   out_data_o,
  input  logic             out_ready_i
);

  logic [7:0] kl, kh, ymin, ymax, y;
  logic signed [8:0] dd;
  est_pkg::item_t item_d, item_q;
  logic valid_q;

  assign kl   = cfg_i.luma_knees[7:0];
  assign kh   = cfg_i.luma_knees[15:8];
  assign ymin = cfg_i.luma_limits[7:0];
  assign ymax = cfg_i.luma_limits[15:8];
  assign y    = in_data_i.luma;

  always_comb begin
    item_d    = '0;
    dd        = '0;
    item_d.cr = in_data_i.chroma_red;
    item_d.cb = in_data_i.chroma_blue;
    if (y < kl) begin
      item_d.seg  = est_pkg::SEG_LOW;
      item_d.step = 8'(kl - y);
      item_d.lin  = 9'($signed({1'b0, y}) - $signed({1'b0, ymin}));
      dd          = $signed({1'b0, kl}) - $signed({1'b0, ymin});
    end else if (y > kh) begin
      item_d.seg  = est_pkg::SEG_HIGH;
      item_d.step = 8'(y - kh);
      item_d.lin  = 9'($signed({1'b0, ymax}) - $signed({1'b0, y}));
      dd          = $signed({1'b0, ymax}) - $signed({1'b0, kh});
    end else begin
      item_d.seg = est_pkg::SEG_MID;
    end
    // empty ramp span leaves mean and width at their edge values
    item_d.ramp   = (item_d.seg != est_pkg::SEG_MID) && (dd > 9'sd0);
    item_d.span_d = dd[7:0];
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

@@ rtl/est_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// est_queue
// Short FIFO of classified pixels between front end and back end.
// ----------------------------------------------------------------------------
module est_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  input  est_pkg::item_t       push_data_i,
  output logic                 push_ready_o,
  input  logic                 pop_i,
  output est_pkg::item_t       head_o,
  output est_pkg::queue_stat_t stat_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  est_pkg::item_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic push;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign push_ready_o = !stat_o.full;
  assign push         = push_valid_i && !stat_o.full;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/est_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// est_div
// Pipelined restoring divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module est_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 8,
  parameter int Q_W   = 24,
  parameter int SB_W  = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [SB_W-1:0]  sb_i,
  output logic [Q_W-1:0]   quo_o,
  output logic [SB_W-1:0]  sb_o
);

  localparam int CW = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

  logic [NUM_W-1:0] rem_q [Q_W+1];
  logic [DEN_W-1:0] den_q [Q_W+1];
  logic [Q_W-1:0]   quo_q [Q_W+1];
  logic             sat_q [Q_W+1];
  logic [SB_W-1:0]  sb_q  [Q_W+1];

  // quotient too large for Q_W bits: flag it and force all ones
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      sat_q[0] <= (CW'(num_i) >> Q_W) >= CW'(den_i);
      sb_q[0]  <= sb_i;
    end
  end

  for (genvar s = 1; s <= Q_W; s++) begin : g_stage
    localparam int J = Q_W - s;
    logic [CW-1:0] shd;
    logic          ge;

    assign shd = CW'(den_q[s-1]) << J;
    assign ge  = CW'(rem_q[s-1]) >= shd;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? NUM_W'(CW'(rem_q[s-1]) - shd) : rem_q[s-1];
        den_q[s] <= den_q[s-1];
        quo_q[s] <= quo_q[s-1] | (ge ? (Q_W'(1) << J) : '0);
        sat_q[s] <= sat_q[s-1];
        sb_q[s]  <= sb_q[s-1];
      end
    end
  end

  assign quo_o = sat_q[Q_W] ? '1 : quo_q[Q_W];
  assign sb_o  = sb_q[Q_W];

endmodule

@@ rtl/est_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// est_back
// Chroma warp, rotation and ellipse distance pipeline with output register.
// ----------------------------------------------------------------------------
module est_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  est_pkg::cfg_t        cfg_i,
  input  est_pkg::item_t       head_i,
  input  est_pkg::queue_stat_t q_stat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  output est_pkg::score_t      out_data_o,
  input  logic                 out_ready_i
);

  localparam int QW  = est_pkg::DIV_Q_W;
  localparam int LAT = 2 * QW + 9;

  logic [LAT-1:0] vld_q;
  logic adv;
  logic signed [23:0] t_s [2];

  assign adv         = !vld_q[LAT-1] || out_ready_i;
  assign pop_o       = adv && !q_stat_i.empty;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], pop_o};
    end
  end

  // Per-channel warp: index 0 is Cr, index 1 is Cb
  for (genvar CH = 0; CH < 2; CH++) begin : g_chan
    localparam logic [7:0] BASE    = (CH == 0) ? est_pkg::BASE_CR : est_pkg::BASE_CB;
    localparam logic [4:0] SPAN_LO = (CH == 0) ? est_pkg::SPAN_CR_LO : est_pkg::SPAN_CB_LO;
    localparam logic [4:0] SPAN_HI = (CH == 0) ? est_pkg::SPAN_CR_HI : est_pkg::SPAN_CB_HI;
    localparam logic       LO_NEG  = (CH == 0);

    logic [7:0]  c, wl, wh, we;
    logic [15:0] wc;
    logic        low, mid, span_neg;
    logic [4:0]  span;
    logic [12:0] sp;
    logic signed [17:0] wdiff;
    logic signed [26:0] wprod;
    logic [26:0] wabs;
    logic [23:0] m_num, w_num;
    logic [7:0]  den1;

    assign c  = (CH == 0) ? head_i.cr : head_i.cb;
    assign wl = (CH == 0) ? cfg_i.edge_widths[7:0]   : cfg_i.edge_widths[23:16];
    assign wh = (CH == 0) ? cfg_i.edge_widths[15:8]  : cfg_i.edge_widths[31:24];
    assign wc = (CH == 0) ? cfg_i.center_widths[15:0] : cfg_i.center_widths[31:16];

    // ramp numerators: mean offset and width offset over the knee span
    always_comb begin
      low      = (head_i.seg == est_pkg::SEG_LOW);
      mid      = (head_i.seg == est_pkg::SEG_MID);
      we       = low ? wl : wh;
      span     = low ? SPAN_LO : SPAN_HI;
      span_neg = low && LO_NEG;
      sp       = 13'(span) * 13'(head_i.step);
      wdiff    = $signed({2'b00, wc}) - $signed({2'b00, we, 8'h00});
      wprod    = $signed(27'($signed(head_i.lin))) * $signed(27'(wdiff));
      wabs     = wprod[26] ? 27'(-wprod) : 27'(wprod);
      if (head_i.ramp) begin
        m_num = 24'({sp, 8'h00});
        w_num = wabs[23:0];
        den1  = head_i.span_d;
      end else begin
        m_num = '0;
        w_num = '0;
        den1  = 8'd1;
      end
    end

    logic [QW-1:0] mq_mag, wq_mag, q2_mag;
    logic [9:0]    m_sb, sb2;
    logic [8:0]    w_sb;

    est_div #(
      .NUM_W(est_pkg::DIV1_NUM_W), .DEN_W(est_pkg::DIV1_DEN_W), .Q_W(QW), .SB_W(10)
    ) u_div_mean (
      .clk_i (clk_i), .en_i (adv), .num_i (m_num), .den_i (den1),
      .sb_i ({span_neg, mid, c}), .quo_o (mq_mag), .sb_o (m_sb)
    );

    est_div #(
      .NUM_W(est_pkg::DIV1_NUM_W), .DEN_W(est_pkg::DIV1_DEN_W), .Q_W(QW), .SB_W(9)
    ) u_div_width (
      .clk_i (clk_i), .en_i (adv), .num_i (w_num), .den_i (den1),
      .sb_i ({wprod[26], we}), .quo_o (wq_mag), .sb_o (w_sb)
    );

    logic       m_neg, m_mid, w_neg;
    logic [7:0] m_c, w_e;
    logic signed [25:0] mq, mean, wq, width;
    logic [24:0] width_c;
    logic signed [26:0] diff, dabs;
    logic [20:0] dmag;
    logic [36:0] pmag, num2;
    logic [24:0] den2;

    assign {m_neg, m_mid, m_c} = m_sb;
    assign {w_neg, w_e}        = w_sb;

    // warp numerator (C - mean) * Wc over the luma-dependent width
    always_comb begin
      mq      = m_neg ? -$signed({2'b00, mq_mag}) : $signed({2'b00, mq_mag});
      mean    = $signed({10'd0, BASE, 8'h00}) + mq;
      wq      = w_neg ? -$signed({2'b00, wq_mag}) : $signed({2'b00, wq_mag});
      width   = $signed({10'd0, w_e, 8'h00}) + wq;
      width_c = (width < 26'sd1) ? 25'd1 : width[24:0];
      diff    = $signed({11'd0, m_c, 8'h00}) - 27'(mean);
      dabs    = diff[26] ? -diff : diff;
      dmag    = dabs[20:0];
      pmag    = 37'(dmag) * 37'(wc);
      num2    = m_mid ? '0 : pmag;
      den2    = m_mid ? 25'd1 : width_c;
    end

    est_div #(
      .NUM_W(est_pkg::DIV2_NUM_W), .DEN_W(est_pkg::DIV2_DEN_W), .Q_W(QW), .SB_W(10)
    ) u_div_warp (
      .clk_i (clk_i), .en_i (adv), .num_i (num2), .den_i (den2),
      .sb_i ({diff[26], m_mid, m_c}), .quo_o (q2_mag), .sb_o (sb2)
    );

    logic       t_neg, t_mid;
    logic [7:0] t_c;
    logic signed [25:0] q2, tt;
    logic signed [23:0] t_ch;

    assign {t_neg, t_mid, t_c} = sb2;

    always_comb begin
      q2 = t_neg ? -$signed({2'b00, q2_mag}) : $signed({2'b00, q2_mag});
      tt = $signed({10'd0, BASE, 8'h00}) + q2;
      if (t_mid) begin
        t_ch = $signed(24'({t_c, 8'h00}));
      end else if (tt > 26'sd8388607) begin
        t_ch = 24'sh7FFFFF;
      end else if (tt < -26'sd8388608) begin
        t_ch = 24'sh800000;
      end else begin
        t_ch = tt[23:0];
      end
    end

    assign t_s[CH] = t_ch;
  end

  // Rotation and ellipse distance
  logic signed [15:0] cs, sn, ecx, ecy;
  logic [23:0] ia, ib;
  assign cs  = $signed(cfg_i.rotation[15:0]);
  assign sn  = $signed(cfg_i.rotation[31:16]);
  assign ecx = $signed(cfg_i.ellipse_offset[15:0]);
  assign ecy = $signed(cfg_i.ellipse_offset[31:16]);
  assign ia  = cfg_i.inv_axes[23:0];
  assign ib  = cfg_i.inv_axes[47:24];

  logic signed [24:0] dx_q, dy_q;
  logic signed [40:0] p_cx_q, p_sy_q, p_sx_q, p_cy_q;
  logic signed [20:0] ex_q, ey_q, ex_d, ey_d;
  logic [38:0] ex2_q, ey2_q, ex2_d, ey2_d;
  logic [43:0] axl_q, ayl_q;
  logic [42:0] axh_q, ayh_q;
  logic [62:0] sx_q, sy_q;
  est_pkg::score_t score_q, score_d;

  logic signed [41:0] sum_x, sum_y, sq_x, sq_y;
  logic signed [27:0] xx, yy;
  logic signed [28:0] ex_raw, ey_raw;
  logic [63:0] d_sum;
  logic [39:0] dgap;
  logic [48:0] sprod;

  always_comb begin
    sum_x  = 42'(p_cx_q) + 42'(p_sy_q);
    sum_y  = 42'(p_cy_q) - 42'(p_sx_q);
    xx     = 28'(sum_x >>> 14);
    yy     = 28'(sum_y >>> 14);
    ex_raw = 29'(xx) - 29'(ecx);
    ey_raw = 29'(yy) - 29'(ecy);
    if (ex_raw > 29'sd524288)       ex_d = 21'sd524288;
    else if (ex_raw < -29'sd524288) ex_d = -21'sd524288;
    else                            ex_d = ex_raw[20:0];
    if (ey_raw > 29'sd524288)       ey_d = 21'sd524288;
    else if (ey_raw < -29'sd524288) ey_d = -21'sd524288;
    else                            ey_d = ey_raw[20:0];
    sq_x  = 42'(ex_q) * 42'(ex_q);
    sq_y  = 42'(ey_q) * 42'(ey_q);
    ex2_d = sq_x[38:0];
    ey2_d = sq_y[38:0];
  end

  // score = 510 * (0.5 - D) in Q0.40, dropped to an integer
  always_comb begin
    d_sum   = 64'(sx_q) + 64'(sy_q);
    dgap    = '0;
    sprod   = '0;
    score_d = '0;
    if (d_sum <= est_pkg::HALF_Q40) begin
      dgap     = 40'(est_pkg::HALF_Q40 - d_sum);
      sprod    = 49'({dgap, 9'd0}) - 49'({dgap, 1'b0});
      score_d.skin_score = sprod[47:40];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q    <= 25'(t_s[1]) - $signed({9'd0, cfg_i.cluster_center[15:0]});
      dy_q    <= 25'(t_s[0]) - $signed({9'd0, cfg_i.cluster_center[31:16]});
      p_cx_q  <= 41'(cs) * 41'(dx_q);
      p_sy_q  <= 41'(sn) * 41'(dy_q);
      p_sx_q  <= 41'(sn) * 41'(dx_q);
      p_cy_q  <= 41'(cs) * 41'(dy_q);
      ex_q    <= ex_d;
      ey_q    <= ey_d;
      ex2_q   <= ex2_d;
      ey2_q   <= ey2_d;
      axl_q   <= 44'(ex2_q[19:0]) * 44'(ia);
      axh_q   <= 43'(ex2_q[38:20]) * 43'(ia);
      ayl_q   <= 44'(ey2_q[19:0]) * 44'(ib);
      ayh_q   <= 43'(ey2_q[38:20]) * 43'(ib);
      sx_q    <= 63'({axh_q, 20'd0}) + 63'(axl_q);
      sy_q    <= 63'({ayh_q, 20'd0}) + 63'(ayl_q);
      score_q <= score_d;
    end
  end

  assign out_data_o = score_q;

endmodule

@@ rtl/elliptical_skin_tone_score_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elliptical_skin_tone_score_core
// YCbCr elliptical skin color model: one 8-bit skin likelihood per pixel.
//
//   channel   dir   transaction    payload
//   pixel_i   in    valid & ready  luma, chroma_red, chroma_blue
//   score_o   out   valid & ready  skin_score
//   cfg       in    cfg_we_i       cfg_idx_i, cfg_data_i
//
// One pixel per clock sustained while score_o is not stalled. From acceptance
// to result with an empty queue a pixel passes the front register, the queue,
// then 57 back-end stages, set mostly by the two 24-stage restoring dividers
// of the chroma warp. Reset is asynchronous and loads the published model
// constants. An output stall freezes the back end; the queue then absorbs
// pixels until it fills, after which pixel_i.ready drops.
// ----------------------------------------------------------------------------
`include "elliptical_skin_tone_score_core_macros.svh"

module elliptical_skin_tone_score_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  est_stream_if.sink                          pixel_i,
  est_stream_if.source                        score_o,
  input  logic                                cfg_we_i,
  input  logic [est_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [est_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  est_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= est_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      case (est_pkg::reg_idx_e'(cfg_idx_i))
        est_pkg::REG_LUMA_KNEES:     cfg_q.luma_knees     <= cfg_data_i[15:0];
        est_pkg::REG_LUMA_LIMITS:    cfg_q.luma_limits    <= cfg_data_i[15:0];
        est_pkg::REG_EDGE_WIDTHS:    cfg_q.edge_widths    <= cfg_data_i[31:0];
        est_pkg::REG_CENTER_WIDTHS:  cfg_q.center_widths  <= cfg_data_i[31:0];
        est_pkg::REG_CLUSTER_CENTER: cfg_q.cluster_center <= cfg_data_i[31:0];
        est_pkg::REG_ELLIPSE_OFFSET: cfg_q.ellipse_offset <= cfg_data_i[31:0];
        est_pkg::REG_ROTATION:       cfg_q.rotation       <= cfg_data_i[31:0];
        est_pkg::REG_INV_AXES:       cfg_q.inv_axes       <= cfg_data_i[47:0];
        default: begin
        end
      endcase
    end
  end

  logic                 f_valid, f_ready, pop;
  est_pkg::item_t       f_item, head;
  est_pkg::queue_stat_t q_stat;

  est_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (pixel_i.valid),
    .in_data_i   (pixel_i.payload),
    .in_ready_o  (pixel_i.ready),
    .out_valid_o (f_valid),
    .out_data_o  (f_item),
    .out_ready_i (f_ready)
  );

  est_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_data_i  (f_item),
    .push_ready_o (f_ready),
    .pop_i        (pop),
    .head_o       (head),
    .stat_o       (q_stat)
  );

  est_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (score_o.valid),
    .out_data_o  (score_o.payload),
    .out_ready_i (score_o.ready)
  );

  `EST_ASSERT(a_queue_stat, !(q_stat.empty && q_stat.full), "queue both empty and full")
  `EST_ASSERT(a_pop_nonempty, !(pop && q_stat.empty), "pop from empty queue")
  `EST_ASSERT_NEXT(a_front_holds, pixel_i.valid && pixel_i.ready, f_valid, "pixel lost")
  `EST_ASSERT_NEXT(a_full_blocks, f_valid && q_stat.full && !pop, !pixel_i.ready || !f_valid, "front overrun")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the elliptical skin tone score core against a fixed-point score
// predictor. Outside calm phases pixels arrive in bursts and the score side
// stalls at random. Each score is compared with the oldest predicted score.
// Register settings change between phases, only while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import est_pkg::*;

  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 400000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  est_stream_if #(.payload_t(pixel_t)) pix_if ();
  est_stream_if #(.payload_t(score_t)) score_if ();

  elliptical_skin_tone_score_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pixel_i    (pix_if.sink),
    .score_o    (score_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  cfg_t       cur_cfg;
  pixel_t     pending_pixels[$];
  logic [7:0] expected_scores[$];
  int         fail_count;
  int         cycle_count;
  int         burst_left;
  int         gap_left;
  bit         calm;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Luma-dependent chroma warp, Q8.8 result saturated to signed 24 bits
  function automatic longint warp_chroma(longint c, longint y, longint base,
                                         longint lo_span, longint hi_span,
                                         longint wl, longint wh, longint wc);
    longint kl, kh, ymin, ymax, d, mean, width, t;
    kl   = cur_cfg.luma_knees[7:0];
    kh   = cur_cfg.luma_knees[15:8];
    ymin = cur_cfg.luma_limits[7:0];
    ymax = cur_cfg.luma_limits[15:8];
    if (y < kl) begin
      d     = kl - ymin;
      mean  = base * 256;
      width = wl * 256;
      if (d > 0) begin
        mean  += lo_span * 256 * (kl - y) / d;
        width += (y - ymin) * (wc - wl * 256) / d;
      end
    end else if (y > kh) begin
      d     = ymax - kh;
      mean  = base * 256;
      width = wh * 256;
      if (d > 0) begin
        mean  += hi_span * 256 * (y - kh) / d;
        width += (ymax - y) * (wc - wh * 256) / d;
      end
    end else begin
      return c * 256;
    end
    if (width < 1) width = 1;
    t = (c * 256 - mean) * wc / width + base * 256;
    if (t > 64'sd8388607) t = 64'sd8388607;
    if (t < -64'sd8388608) t = -64'sd8388608;
    return t;
  endfunction

  function automatic longint clamp_span(longint v);
    if (v > 64'sd524288) return 64'sd524288;
    if (v < -64'sd524288) return -64'sd524288;
    return v;
  endfunction

  function automatic logic [7:0] predict_skin_score(pixel_t p);
    longint tcr, tcb, dx, dy, cs, sn, ex, ey;
    longint unsigned d_sum, half;
    logic [7:0] score;
    half = 64'd1 << 39;
    tcr = warp_chroma(p.chroma_red, p.luma, BASE_CR, -longint'(SPAN_CR_LO),
                      SPAN_CR_HI, cur_cfg.edge_widths[7:0],
                      cur_cfg.edge_widths[15:8], cur_cfg.center_widths[15:0]);
    tcb = warp_chroma(p.chroma_blue, p.luma, BASE_CB, SPAN_CB_LO, SPAN_CB_HI,
                      cur_cfg.edge_widths[23:16], cur_cfg.edge_widths[31:24],
                      cur_cfg.center_widths[31:16]);
    dx = tcb - longint'(cur_cfg.cluster_center[15:0]);
    dy = tcr - longint'(cur_cfg.cluster_center[31:16]);
    cs = longint'($signed(cur_cfg.rotation[15:0]));
    sn = longint'($signed(cur_cfg.rotation[31:16]));
    ex = clamp_span(((cs * dx + sn * dy) >>> 14)
                    - longint'($signed(cur_cfg.ellipse_offset[15:0])));
    ey = clamp_span(((-sn * dx + cs * dy) >>> 14)
                    - longint'($signed(cur_cfg.ellipse_offset[31:16])));
    d_sum = longint'(ex * ex) * longint'(cur_cfg.inv_axes[23:0])
          + longint'(ey * ey) * longint'(cur_cfg.inv_axes[47:24]);
    score = 8'd0;
    if (d_sum <= half) score = 8'((64'd510 * (half - d_sum)) >> 40);
    return score;
  endfunction

  // Driver: present pending pixels in bursts, predict on each transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_if.valid   <= 1'b0;
      pix_if.payload <= '0;
      burst_left     <= 0;
      gap_left       <= 0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        expected_scores.push_back(predict_skin_score(pix_if.payload));
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (gap_left > 0) begin
          gap_left     <= gap_left - 1;
          pix_if.valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          pix_if.payload <= pending_pixels.pop_front();
          pix_if.valid   <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(0, 12);
            gap_left   <= calm ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall the score side, compare each transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_if.ready <= 1'b0;
    end else begin
      score_if.ready <= calm ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (score_if.valid && score_if.ready) begin
        if (expected_scores.size() == 0) begin
          $error("skin_score: unexpected result %0d", score_if.payload.skin_score);
          fail_count++;
        end else begin
          logic [7:0] want;
          want = expected_scores.pop_front();
          if (score_if.payload.skin_score !== want) begin
            $error("skin_score: expected %0d, actual %0d", want,
                   score_if.payload.skin_score);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic load_settings(cfg_t c);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= REG_LUMA_KNEES;     cfg_data_i <= 48'(c.luma_knees);
    @(posedge clk_i);
    cfg_idx_i <= REG_LUMA_LIMITS;    cfg_data_i <= 48'(c.luma_limits);
    @(posedge clk_i);
    cfg_idx_i <= REG_EDGE_WIDTHS;    cfg_data_i <= 48'(c.edge_widths);
    @(posedge clk_i);
    cfg_idx_i <= REG_CENTER_WIDTHS;  cfg_data_i <= 48'(c.center_widths);
    @(posedge clk_i);
    cfg_idx_i <= REG_CLUSTER_CENTER; cfg_data_i <= 48'(c.cluster_center);
    @(posedge clk_i);
    cfg_idx_i <= REG_ELLIPSE_OFFSET; cfg_data_i <= 48'(c.ellipse_offset);
    @(posedge clk_i);
    cfg_idx_i <= REG_ROTATION;       cfg_data_i <= 48'(c.rotation);
    @(posedge clk_i);
    cfg_idx_i <= REG_INV_AXES;       cfg_data_i <= c.inv_axes;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic queue_pixel(int y, int cr, int cb);
    pixel_t p;
    p.luma        = 8'(y);
    p.chroma_red  = 8'(cr);
    p.chroma_blue = 8'(cb);
    pending_pixels.push_back(p);
  endtask

  // Mostly pixels near the skin cluster so the ellipse interior is reached
  task automatic queue_random_pixels(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0)
        queue_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255));
      else
        queue_pixel($urandom_range(0, 255), $urandom_range(125, 180),
                    $urandom_range(80, 140));
    end
  endtask

  // Wait until the last pixel is taken and every score has come back
  task automatic wait_idle();
    wait (pending_pixels.size() == 0 && !pix_if.valid && expected_scores.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic cfg_t mixed_settings();
    cfg_t c;
    c = CFG_RESET;
    if ($urandom_range(0, 1)) c.luma_knees     = 16'($urandom);
    if ($urandom_range(0, 1)) c.luma_limits    = 16'($urandom);
    if ($urandom_range(0, 1)) c.edge_widths    = $urandom;
    if ($urandom_range(0, 1)) c.center_widths  = $urandom;
    if ($urandom_range(0, 1)) c.cluster_center = $urandom;
    if ($urandom_range(0, 1)) c.ellipse_offset = $urandom;
    if ($urandom_range(0, 1)) c.rotation       = $urandom;
    if ($urandom_range(0, 1)) c.inv_axes       = {16'($urandom), $urandom};
    return c;
  endfunction

  initial begin
    cfg_t c;
    fail_count  = 0;
    cycle_count = 0;
    calm        = 1'b0;
    cur_cfg     = CFG_RESET;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: field extremes, knee and limit edges, cluster centre
    queue_pixel(0, 0, 0);
    queue_pixel(255, 255, 255);
    queue_pixel(0, 255, 0);
    queue_pixel(255, 0, 255);
    queue_pixel(124, 152, 109);
    queue_pixel(125, 152, 109);
    queue_pixel(188, 152, 109);
    queue_pixel(189, 152, 109);
    queue_pixel(16, 150, 110);
    queue_pixel(235, 150, 110);
    queue_pixel(5, 150, 110);
    queue_pixel(250, 150, 110);
    queue_pixel(150, 152, 109);
    queue_pixel(150, 155, 105);
    queue_pixel(150, 170, 90);
    queue_random_pixels(500);
    wait_idle();

    // Crossed knees
    c = CFG_RESET;
    c.luma_knees = {8'd100, 8'd200};
    load_settings(c);
    queue_pixel(150, 152, 109);
    queue_pixel(99, 152, 109);
    queue_pixel(201, 152, 109);
    queue_random_pixels(100);
    wait_idle();

    // Empty ramp spans on both sides, extrapolated luma
    c = CFG_RESET;
    c.luma_knees  = {8'd240, 8'd10};
    c.luma_limits = {8'd200, 8'd50};
    calm = 1'b1;
    load_settings(c);
    queue_pixel(5, 150, 110);
    queue_pixel(250, 150, 110);
    queue_random_pixels(100);
    wait_idle();

    // Zero widths force the width floor
    c = CFG_RESET;
    c.edge_widths   = '0;
    c.center_widths = '0;
    calm = 1'b0;
    load_settings(c);
    queue_pixel(16, 150, 110);
    queue_random_pixels(100);
    wait_idle();

    c = '1;
    load_settings(c);
    queue_random_pixels(100);
    wait_idle();

    c = '0;
    load_settings(c);
    queue_random_pixels(100);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      calm = (ph == 2);
      load_settings(mixed_settings());
      queue_random_pixels(200);
      wait_idle();
    end

    calm = 1'b0;
    load_settings(CFG_RESET);
    queue_random_pixels(200);
    wait_idle();

    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/est_pkg.sv
rtl/est_stream_if.sv
rtl/est_front.sv
rtl/est_queue.sv
rtl/est_div.sv
rtl/est_back.sv
rtl/elliptical_skin_tone_score_core.sv
tb/sv/tb_top.sv
